@@ rtl/gffra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffra_pkg
// Shared types and codes for the guarded first-fit range allocator.
// ----------------------------------------------------------------------------
package gffra_pkg;

   localparam int ADDR_W   = 48;
   localparam int XADDR_W  = 52;   // headroom for cursor + range + guards
   localparam int SIZE_W   = 40;
   localparam int OFF_W    = 12;
   localparam int PAGES_W  = 28;
   localparam int TOTAL_W  = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      MODE_ALLOC_NORMAL = 2'd0,
      MODE_ALLOC_DEVICE = 2'd1,
      MODE_FREE_NORMAL  = 2'd2,
      MODE_FREE_DEVICE  = 2'd3
   } mode_type;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_WRONGKIND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

   localparam logic CSR_WINDOW_START = 1'b0;
   localparam logic CSR_WINDOW_END   = 1'b1;

   localparam logic [ADDR_W-1:0] WINDOW_END_RESET = 48'h2000_0000_0000;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [PAGES_W-1:0] pages;
      logic               device;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FIT,
      S_INS_RD,
      S_INS_WR,
      S_INS_NEW,
      S_FREE_RD,
      S_FREE_CHK,
      S_REM_RD,
      S_REM_WR,
      S_REM_FIN
   } state_type;

endpackage

@@ rtl/gffra_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffra_req_if / gffra_rsp_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface gffra_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       mode;
   logic [gffra_pkg::SIZE_W-1:0]     size_bytes;
   logic [gffra_pkg::OFF_W-1:0]      page_offset;
   logic [gffra_pkg::ADDR_W-1:0]     address;
   modport source (output valid, mode, size_bytes, page_offset, address, input ready);
   modport sink   (input valid, mode, size_bytes, page_offset, address, output ready);
endinterface

interface gffra_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [gffra_pkg::STATUS_W-1:0]   status;
   logic [gffra_pkg::ADDR_W-1:0]     result_address;
   logic [gffra_pkg::PAGES_W-1:0]    range_pages;
   logic [gffra_pkg::TOTAL_W-1:0]    normal_pages_total;
   modport source (output valid, status, result_address, range_pages, normal_pages_total,
                   input ready);
   modport sink   (input valid, status, result_address, range_pages, normal_pages_total,
                   output ready);
endinterface

@@ rtl/guarded_first_fit_range_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guarded_first_fit_range_allocator_top
// Address-sorted range allocator with guard pages, first-fit placement.
// ----------------------------------------------------------------------------
// One request item is handled at a time; ready is low while it is at work.
// The table lives in a single-port-read memory, so every step touches one
// entry: address, then registered data. An allocation scans the entries
// from the lowest until a gap fits or the entries run out, checks the
// window end, moves the entries above the insertion slot up by one, top
// first, and writes the new entry; one that misses the window answers from
// the fit check. A free scans for its entry and pulls the entries above it
// down by one; one that stops with an error answers from the check state.
// Errors caught at decode answer straight from the decode state. Ready
// returns the cycle after the response item is taken.
// The window registers may only be written while the block is idle.
// ----------------------------------------------------------------------------
module guarded_first_fit_range_allocator_top #(
   parameter int MAX_RANGES = 64,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   gffra_req_if.sink                         req_ch,
   gffra_rsp_if.source                       rsp_ch,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [gffra_pkg::ADDR_W-1:0]      csr_wr_data
);

   localparam int IW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW   = $clog2(MAX_RANGES + 1);
   localparam int LOGP = $clog2(PAGE_BYTES);
   localparam int AW   = gffra_pkg::XADDR_W;
   localparam int A48  = gffra_pkg::ADDR_W;
   localparam int PW   = gffra_pkg::PAGES_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
   localparam logic [AW-1:0] PB = AW'(PAGE_BYTES);
   localparam logic [gffra_pkg::OFF_W-1:0] OFF_MASK = gffra_pkg::OFF_W'(PAGE_BYTES - 1);

   gffra_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  idx_ff, idx_in, pos_ff, pos_in, count_ff, count_in;
   logic [AW-1:0]  cursor_ff, cursor_in, need_ff, need_in;
   logic [PW-1:0]  pages_ff, pages_in;
   logic [gffra_pkg::OFF_W-1:0] off_ff, off_in;
   logic [1:0]     mode_ff, mode_in;
   logic [gffra_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [A48-1:0] addr_ff, addr_in;
   logic [gffra_pkg::TOTAL_W-1:0] normal_ff, normal_in;
   logic [A48-1:0] win_start_ff, win_end_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [gffra_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [A48-1:0] rsp_addr_ff, rsp_addr_in;
   logic [PW-1:0]  rsp_pages_ff, rsp_pages_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr, rd_addr;
   gffra_pkg::entry_type wr_data, rd_data;

   logic [gffra_pkg::SIZE_W:0] round_sum;
   logic [gffra_pkg::SIZE_W:0] pages_full;
   logic [AW-1:0] ent_start, ent_begin, ent_next;
   logic          is_alloc, is_dev;

   gffra_table #(.DEPTH(MAX_RANGES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == gffra_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.range_pages = rsp_pages_ff;
   assign rsp_ch.normal_pages_total = normal_ff;

   assign is_alloc = (mode_ff == gffra_pkg::MODE_ALLOC_NORMAL) ||
                     (mode_ff == gffra_pkg::MODE_ALLOC_DEVICE);
   assign is_dev   = (mode_ff == gffra_pkg::MODE_ALLOC_DEVICE) ||
                     (mode_ff == gffra_pkg::MODE_FREE_DEVICE);

   // round size plus device offset up to whole pages
   assign round_sum  = {1'b0, size_ff} + (gffra_pkg::SIZE_W+1)'(off_ff)
                       + (gffra_pkg::SIZE_W+1)'(PAGE_BYTES - 1);
   assign pages_full = round_sum >> LOGP;

   // entry geometry: lower guard and first byte past upper guard
   assign ent_start = AW'(rd_data.start);
   assign ent_begin = ent_start - PB;
   assign ent_next  = ent_start + (AW'(rd_data.pages) << LOGP) + PB;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gffra_pkg::S_IDLE;
         count_ff     <= '0;
         normal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         win_start_ff <= '0;
         win_end_ff   <= gffra_pkg::WINDOW_END_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         normal_ff    <= normal_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == gffra_pkg::CSR_WINDOW_START) begin
            win_start_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == gffra_pkg::CSR_WINDOW_END) begin
            win_end_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      cursor_ff     <= cursor_in;
      need_ff       <= need_in;
      pages_ff      <= pages_in;
      off_ff        <= off_in;
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pages_ff  <= rsp_pages_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      need_in       = need_ff;
      pages_in      = pages_ff;
      off_in        = off_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      normal_in     = normal_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pages_in  = rsp_pages_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IW-1:0];
      wr_data       = rd_data;
      rd_addr       = idx_ff[IW-1:0];

      case (state_ff)
         gffra_pkg::S_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               mode_in  = req_ch.mode;
               size_in  = req_ch.size_bytes;
               off_in   = (req_ch.mode == gffra_pkg::MODE_ALLOC_DEVICE) ?
                          (req_ch.page_offset & OFF_MASK) : '0;
               addr_in  = req_ch.address;
               state_in = gffra_pkg::S_DECODE;
            end
         end
         gffra_pkg::S_DECODE: begin
            idx_in        = '0;
            rsp_addr_in   = '0;
            rsp_pages_in  = '0;
            pages_in      = PW'(pages_full);
            need_in       = (AW'(pages_full[PW-1:0]) + AW'(2)) << LOGP;
            cursor_in     = AW'(win_start_ff);
            if (is_alloc) begin
               if (size_ff == '0) begin
                  rsp_status_in = gffra_pkg::STAT_ZERO;
                  rsp_valid_in  = 1'b1;
                  state_in      = gffra_pkg::S_IDLE;
               end else if (count_ff >= CNT_MAX) begin
                  rsp_status_in = gffra_pkg::STAT_FULL;
                  rsp_valid_in  = 1'b1;
                  state_in      = gffra_pkg::S_IDLE;
               end else if (|pages_full[gffra_pkg::SIZE_W:PW]) begin
                  rsp_status_in = gffra_pkg::STAT_NOSPACE;
                  rsp_valid_in  = 1'b1;
                  state_in      = gffra_pkg::S_IDLE;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = gffra_pkg::S_FIT;
               end else begin
                  state_in = gffra_pkg::S_SCAN_RD;
               end
            end else begin
               // align the free address down to its page
               addr_in = addr_ff & ~A48'(PAGE_BYTES - 1);
               if (addr_ff == '0) begin
                  rsp_status_in = gffra_pkg::STAT_OK;
                  rsp_valid_in  = 1'b1;
                  state_in      = gffra_pkg::S_IDLE;
               end else if (count_ff == '0) begin
                  rsp_status_in = gffra_pkg::STAT_NOTFOUND;
                  rsp_valid_in  = 1'b1;
                  state_in      = gffra_pkg::S_IDLE;
               end else begin
                  state_in = gffra_pkg::S_FREE_RD;
               end
            end
         end
         gffra_pkg::S_SCAN_RD: begin
            state_in = gffra_pkg::S_SCAN_CHK;
         end
         gffra_pkg::S_SCAN_CHK: begin
            if (ent_start >= PB && ent_begin >= cursor_ff &&
                (ent_begin - cursor_ff) >= need_ff) begin
               pos_in   = idx_ff;
               state_in = gffra_pkg::S_FIT;
            end else begin
               cursor_in = ent_next;
               idx_in    = idx_ff + CW'(1);
               if (idx_ff + CW'(1) == count_ff) begin
                  pos_in   = count_ff;
                  state_in = gffra_pkg::S_FIT;
               end else begin
                  state_in = gffra_pkg::S_SCAN_RD;
               end
            end
         end
         gffra_pkg::S_FIT: begin
            idx_in = count_ff;
            if (cursor_ff + need_ff > AW'(win_end_ff)) begin
               rsp_status_in = gffra_pkg::STAT_NOSPACE;
               rsp_valid_in  = 1'b1;
               state_in      = gffra_pkg::S_IDLE;
            end else begin
               state_in = gffra_pkg::S_INS_RD;
            end
         end
         gffra_pkg::S_INS_RD: begin
            // move entries up by one, top first, until the slot is open
            rd_addr = idx_ff[IW-1:0] - IW'(1);
            if (idx_ff == pos_ff) begin
               state_in = gffra_pkg::S_INS_NEW;
            end else begin
               state_in = gffra_pkg::S_INS_WR;
            end
         end
         gffra_pkg::S_INS_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = gffra_pkg::S_INS_RD;
         end
         gffra_pkg::S_INS_NEW: begin
            wr_en          = 1'b1;
            wr_addr        = pos_ff[IW-1:0];
            wr_data.start  = A48'(cursor_ff + PB);
            wr_data.pages  = pages_ff;
            wr_data.device = is_dev;
            count_in       = count_ff + CW'(1);
            if (!is_dev) begin
               normal_in = normal_ff + gffra_pkg::TOTAL_W'(pages_ff);
            end
            rsp_status_in = gffra_pkg::STAT_OK;
            rsp_addr_in   = A48'(cursor_ff + PB + AW'(off_ff));
            rsp_pages_in  = pages_ff;
            rsp_valid_in  = 1'b1;
            state_in      = gffra_pkg::S_IDLE;
         end
         gffra_pkg::S_FREE_RD: begin
            state_in = gffra_pkg::S_FREE_CHK;
         end
         gffra_pkg::S_FREE_CHK: begin
            if (rd_data.start == addr_ff) begin
               if (rd_data.device != is_dev) begin
                  rsp_status_in = gffra_pkg::STAT_WRONGKIND;
                  rsp_valid_in  = 1'b1;
                  state_in      = gffra_pkg::S_IDLE;
               end else begin
                  pages_in = rd_data.pages;
                  state_in = gffra_pkg::S_REM_RD;
               end
            end else if (idx_ff + CW'(1) == count_ff) begin
               rsp_status_in = gffra_pkg::STAT_NOTFOUND;
               rsp_valid_in  = 1'b1;
               state_in      = gffra_pkg::S_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = gffra_pkg::S_FREE_RD;
            end
         end
         gffra_pkg::S_REM_RD: begin
            // pull entries above the freed slot down by one
            rd_addr = idx_ff[IW-1:0] + IW'(1);
            if (idx_ff + CW'(1) == count_ff) begin
               state_in = gffra_pkg::S_REM_FIN;
            end else begin
               state_in = gffra_pkg::S_REM_WR;
            end
         end
         gffra_pkg::S_REM_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + CW'(1);
            state_in = gffra_pkg::S_REM_RD;
         end
         gffra_pkg::S_REM_FIN: begin
            count_in = count_ff - CW'(1);
            if (!is_dev) begin
               normal_in = normal_ff - gffra_pkg::TOTAL_W'(pages_ff);
            end
            rsp_status_in = gffra_pkg::STAT_OK;
            rsp_addr_in   = addr_ff;
            rsp_pages_in  = pages_ff;
            rsp_valid_in  = 1'b1;
            state_in      = gffra_pkg::S_IDLE;
         end
         default: begin
            state_in = gffra_pkg::S_IDLE;
         end
      endcase
   end

   // table never holds more entries than it has rows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("range count exceeds table depth");

   // an accepted item always goes to decode next
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == gffra_pkg::S_DECODE))
      else $error("accepted item not decoded");

   // a pending response only exists while the sequencer is idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == gffra_pkg::S_IDLE))
      else $error("response pending while busy");

   // the table count changes only on a successful insert or removal
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (rsp_valid_ff && rsp_status_ff == gffra_pkg::STAT_OK))
      else $error("range count changed without an ok response");

endmodule

@@ rtl/gffra_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffra_table
// Range table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gffra_table #(
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  gffra_pkg::entry_type             wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output gffra_pkg::entry_type             rd_data
);

   gffra_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
